@@ design/wtgn_pkg.sv @@
// Shared types, constants and neighbor-wrap function of the tiled Worley noise core.
package wtgn_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned CellW    = 4;
  localparam int unsigned SideW    = 5;
  localparam int unsigned AddrW    = 3 * CellW;
  localparam int unsigned PointW   = 3 * CoordW;
  localparam int unsigned PosW     = 21;
  localparam int unsigned DiffW    = 23;
  localparam int unsigned SqW      = 46;
  localparam int unsigned RootW    = 23;
  localparam int unsigned NoiseW   = 20;
  localparam int unsigned MinSide  = 3;
  localparam int unsigned MaxSide  = 16;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Border shift codes for one axis.
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_NEG  = 2'd1;
  localparam logic [1:0] SH_POS  = 2'd2;

  // Register index of the configuration port.
  localparam logic REG_GRID_SIDE = 1'b0;

  typedef struct packed {
    logic [1:0]       code;
    logic [CellW-1:0] coord;
  } nb_t;

  // Per-read tag that travels beside the memory read.
  typedef struct packed {
    logic       valid;
    logic [1:0] sx;
    logic [1:0] sy;
    logic [1:0] sz;
  } scan_t;

  // Wraps base+off-1 into the interior and reports which border was crossed.
  function automatic nb_t nb_wrap(logic [CellW-1:0] base, logic [1:0] off,
                                  logic [SideW-1:0] side);
    logic [SideW-1:0] n;
    nb_t              r;
    n = {1'b0, base} + {3'b0, off} - 5'd1;
    if (n == 5'd0) begin
      r.code  = SH_NEG;
      r.coord = 4'(side - 5'd2);
    end else if (n == side - 5'd1) begin
      r.code  = SH_POS;
      r.coord = 4'd1;
    end else begin
      r.code  = SH_NONE;
      r.coord = n[CellW-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/wtgn_store.sv @@
// Feature point memory: one write port and one registered read port.
module wtgn_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [wtgn_pkg::AddrW-1:0]  wr_addr,
  input  logic [wtgn_pkg::PointW-1:0] wr_data,
  input  logic [wtgn_pkg::AddrW-1:0]  rd_addr,
  output logic [wtgn_pkg::PointW-1:0] rd_data
);
  import wtgn_pkg::*;

  logic [PointW-1:0] mem [0:(1 << AddrW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/wtgn_dist.sv @@
// Distance pipeline: axis differences, squares and running minimum of squared distance.
module wtgn_dist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  wtgn_pkg::scan_t             scan,
  input  logic [wtgn_pkg::PointW-1:0] rd_data,
  input  logic [wtgn_pkg::SideW-1:0]  side,
  input  logic [wtgn_pkg::PosW-1:0]   pos_x,
  input  logic [wtgn_pkg::PosW-1:0]   pos_y,
  input  logic [wtgn_pkg::PosW-1:0]   pos_z,
  output logic [wtgn_pkg::SqW-1:0]    min_sq
);
  import wtgn_pkg::*;

  scan_t                   tag_r;
  logic                    v1_r, v2_r;
  logic signed [DiffW-1:0] dx_r, dy_r, dz_r;
  logic [SqW-1:0]          qx_r, qy_r, qz_r;
  logic [SqW-1:0]          min_r;
  logic [SqW-1:0]          sum;
  logic signed [DiffW-1:0] dx_nxt, dy_nxt, dz_nxt;

  function automatic logic signed [DiffW-1:0] axis_diff(
      logic [PosW-1:0] pos, logic [CoordW-1:0] f, logic [SideW-1:0] s, logic [1:0] code);
    logic [PosW-1:0]         fs;
    logic [PosW-1:0]         mag;
    logic signed [DiffW-1:0] d;
    fs  = PosW'(f) * PosW'(s);
    mag = {1'b0, 4'(s - 5'd2), 16'b0};
    d   = $signed({2'b0, pos}) - $signed({2'b0, fs});
    if (code == SH_NEG) begin
      d = d + $signed({2'b0, mag});
    end else if (code == SH_POS) begin
      d = d - $signed({2'b0, mag});
    end
    return d;
  endfunction

  // Square of one axis difference, taken on its magnitude.
  function automatic logic [SqW-1:0] axis_sq(logic signed [DiffW-1:0] d);
    logic [DiffW-2:0]   m;
    logic [2*DiffW-3:0] p;
    m = d[DiffW-1] ? (DiffW-1)'(-d) : d[DiffW-2:0];
    p = (2*DiffW-2)'(m) * (2*DiffW-2)'(m);
    return SqW'(p);
  endfunction

  assign dx_nxt = axis_diff(pos_x, rd_data[3*CoordW-1:2*CoordW], side, tag_r.sx);
  assign dy_nxt = axis_diff(pos_y, rd_data[2*CoordW-1:CoordW], side, tag_r.sy);
  assign dz_nxt = axis_diff(pos_z, rd_data[CoordW-1:0], side, tag_r.sz);
  assign sum    = qx_r + qy_r + qz_r;
  assign min_sq = min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      min_r <= '1;
    end else begin
      tag_r <= scan;
      v1_r  <= tag_r.valid;
      v2_r  <= v1_r;
      if (clr) begin
        min_r <= '1;
      end else if (v2_r && sum < min_r) begin
        min_r <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    dz_r <= dz_nxt;
    qx_r <= axis_sq(dx_r);
    qy_r <= axis_sq(dy_r);
    qz_r <= axis_sq(dz_r);
  end

endmodule

@@ design/wtgn_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module wtgn_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wtgn_pkg::SqW-1:0]   value,
  output logic                       done,
  output logic [wtgn_pkg::RootW-1:0] root
);
  import wtgn_pkg::*;

  localparam int unsigned Steps = SqW / 2;

  logic                     busy_r, done_r;
  logic [$clog2(Steps)-1:0] cnt_r;
  logic [SqW-1:0]           v_r, res_r, bit_r;
  logic [SqW-1:0]           trial;

  assign trial = res_r + bit_r;
  assign done  = done_r;
  assign root  = res_r[RootW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(Steps))'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= '0;
      bit_r <= SqW'(1) << (SqW - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

@@ design/worley_tiled_grid_noise_core.sv @@
// Top level of the tiled 3D Worley noise core: control, configuration and result register.
// A query reads the 27 neighbor cells through the single read port, then drains the distance
// pipeline, takes the square root, and finishes with clamp, scaling and output register.
// A load transaction returns no result. One query is in work at a time and
// the next is accepted in the cycle after its result is registered. Synchronous active-low
// reset clears control state; grid_side resets to 8 and the feature memory holds no
// defined value until written.
module worley_tiled_grid_noise_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [wtgn_pkg::CellW-1:0]     in_cell_x,
  input  logic [wtgn_pkg::CellW-1:0]     in_cell_y,
  input  logic [wtgn_pkg::CellW-1:0]     in_cell_z,
  input  logic [wtgn_pkg::CoordW-1:0]    in_point_x,
  input  logic [wtgn_pkg::CoordW-1:0]    in_point_y,
  input  logic [wtgn_pkg::CoordW-1:0]    in_point_z,
  input  logic [wtgn_pkg::CoordW-1:0]    in_query_x,
  input  logic [wtgn_pkg::CoordW-1:0]    in_query_y,
  input  logic [wtgn_pkg::CoordW-1:0]    in_query_z,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [wtgn_pkg::NoiseW-1:0] out_noise_value,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import wtgn_pkg::*;

  // One-hot sequencer for a query.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_ROOT  = 7'b0001000,
    ST_CLAMP = 7'b0010000,
    ST_MULT  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  // floor(y/5) equals (y * ceil(2^24/5)) >> 24 for every y below 2^22.
  localparam logic [23:0] RECIP5 = 24'd3355444;

  state_t           state_r, state_nxt;
  logic [SideW-1:0] grid_side_r;
  logic [SideW-1:0] side_r, side_clamped;
  logic [CellW-1:0] cell_x_r, cell_y_r, cell_z_r;
  logic [PosW-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic [1:0]       ni_r, nj_r, nk_r;
  logic [1:0]       drain_r;
  logic [PosW-1:0]  best_r;
  logic [19:0]      scaled_r;
  logic             out_valid_r;
  logic signed [NoiseW-1:0] noise_r;

  logic             in_acc, query_acc, load_acc, cfg_wr;
  logic             scan_last, out_free;
  nb_t              nbx, nby, nbz;
  scan_t            scan;
  logic [PointW-1:0] rd_data;
  logic [SqW-1:0]   min_sq;
  logic             root_done;
  logic [RootW-1:0] root;
  logic [PosW-1:0]  lim;
  logic [23:0]      x9;
  logic [21:0]      y4;
  logic [45:0]      prod;
  logic signed [PosW:0] diff;

  // Position scaling by s-2: integer part picks the cell, full value is the mapped position.
  function automatic logic [PosW-1:0] map_pos(logic [CoordW-1:0] q, logic [SideW-1:0] s);
    return PosW'(q) * PosW'(s - 5'd2) + PosW'(32'h10000);
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes and configuration. A write updates grid_side at once; a query in
  // work keeps the side it captured when it was accepted.
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign query_acc = in_acc && (in_operation == OP_QUERY);
  assign load_acc  = in_acc && (in_operation == OP_LOAD);
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_GRID_SIDE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_GRID_SIDE) ? {27'b0, grid_side_r} : 32'b0;

  assign out_valid       = out_valid_r;
  assign out_noise_value = noise_r;
  assign out_free        = !out_valid_r || !out_stall;

  // Sides outside the supported range act as the nearest legal side.
  always_comb begin
    if (grid_side_r < SideW'(MinSide)) begin
      side_clamped = SideW'(MinSide);
    end else if (grid_side_r > SideW'(MaxSide)) begin
      side_clamped = SideW'(MaxSide);
    end else begin
      side_clamped = grid_side_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbor scan: one memory read per cycle over the 3x3x3 block around the cell.
  // Border neighbors read the wrapped interior cell and carry a shift code along.
  // ---------------------------------------------------------------------------
  assign nbx       = nb_wrap(cell_x_r, ni_r, side_r);
  assign nby       = nb_wrap(cell_y_r, nj_r, side_r);
  assign nbz       = nb_wrap(cell_z_r, nk_r, side_r);
  assign scan_last = (ni_r == 2'd2) && (nj_r == 2'd2) && (nk_r == 2'd2);

  always_comb begin
    scan.valid = (state_r == ST_SCAN);
    scan.sx    = nbx.code;
    scan.sy    = nby.code;
    scan.sz    = nbz.code;
  end

  wtgn_store u_store (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr ({in_cell_x, in_cell_y, in_cell_z}),
    .wr_data ({in_point_x, in_point_y, in_point_z}),
    .rd_addr ({nbx.coord, nby.coord, nbz.coord}),
    .rd_data (rd_data)
  );

  wtgn_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (query_acc),
    .scan    (scan),
    .rd_data (rd_data),
    .side    (side_r),
    .pos_x   (pos_x_r),
    .pos_y   (pos_y_r),
    .pos_z   (pos_z_r),
    .min_sq  (min_sq)
  );

  // The minimum of the roots is the root of the minimum square, so one root suffices.
  wtgn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == ST_DRAIN) && (drain_r == 2'd3)),
    .value (min_sq),
    .done  (root_done),
    .root  (root)
  );

  // ---------------------------------------------------------------------------
  // Final scaling: noise = 1 - round(0.45 * Dmin), with Dmin clamped to s in Q16.
  // ---------------------------------------------------------------------------
  assign lim  = {side_r, 16'b0};
  assign x9   = {3'b0, best_r} * 24'd9 + 24'd10;
  assign y4   = x9[23:2];
  assign prod = {24'b0, y4} * {22'b0, RECIP5};
  assign diff = $signed(22'h10000) - $signed({2'b0, scaled_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (query_acc) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 2'd3) state_nxt = ST_ROOT;
      ST_ROOT:  if (root_done) state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_side_r <= 5'd8;
      out_valid_r <= 1'b0;
      ni_r        <= '0;
      nj_r        <= '0;
      nk_r        <= '0;
      drain_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        grid_side_r <= pwdata[SideW-1:0];
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (query_acc) begin
        ni_r <= '0;
        nj_r <= '0;
        nk_r <= '0;
      end else if (state_r == ST_SCAN) begin
        if (nk_r != 2'd2) begin
          nk_r <= nk_r + 2'd1;
        end else begin
          nk_r <= '0;
          if (nj_r != 2'd2) begin
            nj_r <= nj_r + 2'd1;
          end else begin
            nj_r <= '0;
            ni_r <= ni_r + 2'd1;
          end
        end
      end
      if (state_r == ST_DRAIN) begin
        drain_r <= drain_r + 2'd1;
      end else begin
        drain_r <= '0;
      end
    end
  end

  // Query operands and result datapath registers.
  always_ff @(posedge clk) begin
    if (query_acc) begin
      side_r   <= side_clamped;
      pos_x_r  <= map_pos(in_query_x, side_clamped);
      pos_y_r  <= map_pos(in_query_y, side_clamped);
      pos_z_r  <= map_pos(in_query_z, side_clamped);
      cell_x_r <= 4'(map_pos(in_query_x, side_clamped) >> 16);
      cell_y_r <= 4'(map_pos(in_query_y, side_clamped) >> 16);
      cell_z_r <= 4'(map_pos(in_query_z, side_clamped) >> 16);
    end
    if (state_r == ST_CLAMP) begin
      best_r <= ({1'b0, root} < {3'b0, lim}) ? root[PosW-1:0] : lim;
    end
    if (state_r == ST_MULT) begin
      scaled_r <= prod[43:24];
    end
    if (state_r == ST_FIN && out_free) begin
      if (diff < -$signed(22'h80000)) begin
        noise_r <= NoiseW'(-$signed(22'h80000));
      end else begin
        noise_r <= diff[NoiseW-1:0];
      end
    end
  end

endmodule

@@ tb/sv/worley_tiled_grid_noise_core_tb.sv @@
// Self-checking testbench for the tiled 3D Worley noise core.
module worley_tiled_grid_noise_core_tb;

  import wtgn_pkg::*;

  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_CFG  = 1'b1;
  localparam int   SAT_FLOOR = -524288;

  // One input transaction as the testbench sees it.
  typedef struct {
    logic        op;
    logic [3:0]  cx, cy, cz;
    logic [15:0] px, py, pz;
    logic [15:0] qx, qy, qz;
  } noise_item_t;

  // One row of the directed table: either a grid_side write or an input transaction.
  // When has_exp is set, the noise value is typed in rather than predicted.
  typedef struct {
    logic        kind;
    logic [4:0]  side;
    logic        op;
    logic [3:0]  cx, cy, cz;
    logic [15:0] px, py, pz;
    logic [15:0] qx, qy, qz;
    logic        has_exp;
    int          exp_val;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = OP_LOAD;
  logic [3:0]  in_cell_x = '0, in_cell_y = '0, in_cell_z = '0;
  logic [15:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [15:0] in_query_x = '0, in_query_y = '0, in_query_z = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [NoiseW-1:0] out_noise_value;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  worley_tiled_grid_noise_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_cell_x(in_cell_x), .in_cell_y(in_cell_y), .in_cell_z(in_cell_z),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_query_x(in_query_x), .in_query_y(in_query_y), .in_query_z(in_query_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_noise_value(out_noise_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the feature-point memory and of the grid_side register.
  logic [15:0] feat_x [4096];
  logic [15:0] feat_y [4096];
  logic [15:0] feat_z [4096];
  logic [4:0]  side_reg = 5'd8;

  // Noise values still owed by the core, oldest first.
  logic signed [NoiseW-1:0] pending_noise[$];
  int errors = 0;
  int burst_left = 4;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous watchdog; the slowest correct run is far shorter than this.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned root_floor_u(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Folds a neighbor coordinate into the interior and gives its scaled border shift.
  function automatic int fold_cell(input int n, input int s, output longint shift);
    if (n <= 0) begin
      shift = -longint'(s - 2) * 65536;
      return s - 2;
    end
    if (n >= s - 1) begin
      shift = longint'(s - 2) * 65536;
      return 1;
    end
    shift = 0;
    return n;
  endfunction

  // Predicts the noise value of a query from the shadow grid and grid_side.
  function automatic logic signed [NoiseW-1:0] predict_noise(input noise_item_t it);
    int              s, i, j, k, cxn, cyn, czn, e;
    int              cid[3];
    longint          pos[3];
    longint          q[3];
    longint          sx, sy, sz, dx, dy, dz, res;
    longint unsigned best, d;
    s = side_reg;
    if (s < MinSide) s = MinSide;
    if (s > MaxSide) s = MaxSide;
    q[0] = it.qx;
    q[1] = it.qy;
    q[2] = it.qz;
    for (i = 0; i < 3; i++) begin
      cid[i] = int'((q[i] * (s - 2)) >>> 16) + 1;
      pos[i] = q[i] * (s - 2) + 65536;
    end
    best = longint'(s) * 65536;
    for (i = -1; i <= 1; i++)
      for (j = -1; j <= 1; j++)
        for (k = -1; k <= 1; k++) begin
          cxn = fold_cell(cid[0] + i, s, sx);
          cyn = fold_cell(cid[1] + j, s, sy);
          czn = fold_cell(cid[2] + k, s, sz);
          e   = (cxn << 8) | (cyn << 4) | czn;
          dx  = pos[0] - (longint'(feat_x[e]) * s + sx);
          dy  = pos[1] - (longint'(feat_y[e]) * s + sy);
          dz  = pos[2] - (longint'(feat_z[e]) * s + sz);
          d   = root_floor_u(dx * dx + dy * dy + dz * dz);
          if (d < best) best = d;
        end
    res = 65536 - longint'((best * 9 + 10) / 20);
    if (res < SAT_FLOOR) res = SAT_FLOOR;
    return res[NoiseW-1:0];
  endfunction

  // Drives one transaction, holds it until accepted, then updates the shadow state.
  // The sender runs in bursts; valid stays high between items of one burst.
  task automatic send_item(input noise_item_t it, input logic has_exp, input int exp_val);
    in_valid     <= 1'b1;
    in_operation <= it.op;
    in_cell_x    <= it.cx;
    in_cell_y    <= it.cy;
    in_cell_z    <= it.cz;
    in_point_x   <= it.px;
    in_point_y   <= it.py;
    in_point_z   <= it.pz;
    in_query_x   <= it.qx;
    in_query_y   <= it.qy;
    in_query_z   <= it.qz;
    do @(posedge clk); while (in_stall);
    if (it.op == OP_LOAD) begin
      feat_x[{it.cx, it.cy, it.cz}] = it.px;
      feat_y[{it.cx, it.cy, it.cz}] = it.py;
      feat_z[{it.cx, it.cy, it.cz}] = it.pz;
    end else if (has_exp) begin
      pending_noise.push_back(exp_val[NoiseW-1:0]);
    end else begin
      pending_noise.push_back(predict_noise(it));
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Writes grid_side once the core is idle. Loads carry no result, so a short
  // pause covers a load that may still be in flight after the last result.
  task automatic write_grid_side(input logic [4:0] value);
    in_valid <= 1'b0;
    while (pending_noise.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_GRID_SIDE, 2'b00};
    pwdata  <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    side_reg  = value;
    @(posedge clk);
  endtask

  // Result checker: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_noise.size() == 0) begin
        report_mismatch("unexpected noise_value", out_noise_value, 0);
      end else begin
        if (out_noise_value !== pending_noise[0])
          report_mismatch("noise_value", out_noise_value, pending_noise[0]);
        void'(pending_noise.pop_front());
      end
    end
  end

  // Receiver back-pressure: alternates between free-running, scattered and long stalls.
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 200);
      out_stall  <= 1'b0;
    end else begin
      stall_span <= stall_span - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Directed table. A feature point of 8192 scaled by side 8 (or 4096 by 16) lands
  // exactly on a query at the origin, so those rows expect the full value of one.
  dir_row_t directed_rows[] = '{
    '{ROW_ITEM, 5'd0, OP_LOAD,  4'd1, 4'd1, 4'd1, 16'h2000, 16'h2000, 16'h2000,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0000, 16'h0000, 16'h0000, 1'b1, 65536},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'hffff, 16'hffff, 16'hffff, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0000, 16'hffff, 16'h8000, 1'b0, 0},
    // Loads at cells 0 and 15 write entries that no query reads; cell 14 is read at side 16.
    '{ROW_ITEM, 5'd0, OP_LOAD,  4'd0, 4'd0, 4'd0, 16'hffff, 16'hffff, 16'hffff,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_LOAD,  4'd15, 4'd15, 4'd15, 16'h0, 16'h0, 16'h0,
      16'hffff, 16'hffff, 16'hffff, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_LOAD,  4'd14, 4'd14, 4'd14, 16'hffff, 16'h0, 16'hffff,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_CFG,  5'd16, OP_LOAD, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_LOAD,  4'd1, 4'd1, 4'd1, 16'h1000, 16'h1000, 16'h1000,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0000, 16'h0000, 16'h0000, 1'b1, 65536},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'hffff, 16'hffff, 16'hffff, 1'b0, 0},
    '{ROW_CFG,  5'd3, OP_LOAD,  4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0000, 16'h0000, 16'h0000, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h8000, 16'h8000, 16'hffff, 1'b0, 0},
    // Out-of-range sides clamp to the nearest legal value.
    '{ROW_CFG,  5'd0, OP_LOAD,  4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h1234, 16'hedcb, 16'h5555, 1'b0, 0},
    '{ROW_CFG,  5'd2, OP_LOAD,  4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'haaaa, 16'h0001, 16'hfffe, 1'b0, 0},
    '{ROW_CFG,  5'd31, OP_LOAD, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'hffff, 16'h0000, 16'hffff, 1'b0, 0},
    '{ROW_CFG,  5'd17, OP_LOAD, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0, 16'h0, 16'h0, 1'b0, 0},
    '{ROW_ITEM, 5'd0, OP_QUERY, 4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h7fff, 16'h8001, 16'h0000, 1'b0, 0},
    '{ROW_CFG,  5'd8, OP_LOAD,  4'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0,
      16'h0, 16'h0, 16'h0, 1'b0, 0}
  };

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  logic [4:0] phase_sides[5] = '{5'd5, 5'd16, 5'd3, 5'd11, 5'd8};

  initial begin
    noise_item_t it;
    dir_row_t    row;
    int          phase, n, x, y, z;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every interior cell at the largest side is written first, so no query
    // at any side reads an entry that was never loaded.
    for (x = 1; x <= 14; x++)
      for (y = 1; y <= 14; y++)
        for (z = 1; z <= 14; z++) begin
          it    = '{OP_LOAD, x[3:0], y[3:0], z[3:0], pick_coord(), pick_coord(),
                    pick_coord(), 16'($urandom()), 16'($urandom()), 16'($urandom())};
          send_item(it, 1'b0, 0);
        end

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        write_grid_side(row.side);
      end else begin
        it = '{row.op, row.cx, row.cy, row.cz, row.px, row.py, row.pz,
               row.qx, row.qy, row.qz};
        send_item(it, row.has_exp, row.exp_val);
      end
    end

    // Random phases, one grid_side setting each; the first uses a random side.
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 0) write_grid_side(5'($urandom_range(0, 31)));
      else write_grid_side(phase_sides[phase - 1]);
      for (n = 0; n < 170; n++) begin
        it.op = ($urandom_range(0, 9) < 6) ? OP_QUERY : OP_LOAD;
        it.cx = 4'($urandom());
        it.cy = 4'($urandom());
        it.cz = 4'($urandom());
        it.px = pick_coord();
        it.py = pick_coord();
        it.pz = pick_coord();
        it.qx = pick_coord();
        it.qy = pick_coord();
        it.qz = pick_coord();
        send_item(it, 1'b0, 0);
      end
    end

    in_valid <= 1'b0;
    while (pending_noise.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/wtgn_pkg.sv
design/wtgn_store.sv
design/wtgn_dist.sv
design/wtgn_sqrt.sv
design/worley_tiled_grid_noise_core.sv
tb/sv/worley_tiled_grid_noise_core_tb.sv
